### rtl/core/edct_pkg.sv
// shared types and constants of the epoch distinct-count detector
`timescale 1ns / 1ps
package edct_pkg;
    localparam int TS_W        = 48;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int CNT_W       = 9;
    localparam int EID_W       = 16;
    localparam int MODE_W      = 2;
    localparam int TICK_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int PAIR_W      = 2 * IP_W;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 64;

    localparam logic [CNT_W-1:0]     COUNT_MAX           = '1;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_PORT_SCAN      = 2'd1;
    localparam logic [MODE_W-1:0]    MODE_DDOS           = 2'd2;
    localparam logic                 KIND_FLUSH          = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_WALK = 6'b000100,
        S_WCHK = 6'b001000,
        S_SCAN = 6'b010000,
        S_SCHK = 6'b100000
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]  key;
        logic [CNT_W-1:0] cnt;
    } t_group;
endpackage

### rtl/core/epoch_distinct_count_threshold_top.sv
// top level of the epoch-windowed distinct-count detector
`timescale 1ns / 1ps
// Packet headers stream in; time is cut into epochs of epoch_ticks ticks, the
// first packet opening the first epoch. Distinct pairs live in a pair memory
// and per-group counts in a group memory, both filled in insertion order and
// cleared at once by resetting their fill counts, so no clearing pass is ever
// needed after reset. A packet that stays in its epoch scans the stored
// entries: each one is read through the registered memory read port in S_SCAN
// and compared in S_SCHK, and a repeated pair ends the scan early. A packet
// that closes an epoch first passes through the bit-serial divider that works
// out how many epochs were skipped, then walks the group memory (S_WALK then
// S_WCHK per entry) emitting every group at or above count_threshold (at
// most 64 per close, in insertion order), and then scans as above. A flush
// word walks the groups the same way. Results wait in an output register,
// and the walk holds only while that register is full and not taken. The
// configuration port is always ready and must be written only while the
// block is idle; the block itself does not enforce this.
module epoch_distinct_count_threshold_top #(
    parameter int PAIR_ENTRIES  = 256,
    parameter int GROUP_ENTRIES = 256,
    parameter int EPOCH_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // timestamp, src_ip, dst_ip, dst_port
    input  logic [edct_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // kind
    input  logic                              i_s_tuser,
    // result words
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // epoch number, group key, distinct count, zero fill
    output logic [edct_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // overflow
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [edct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [edct_pkg::TICK_W-1:0]       i_cfg_data
);
    import edct_pkg::*;

    localparam int PA_W   = $clog2(PAIR_ENTRIES);
    localparam int GA_W   = $clog2(GROUP_ENTRIES);
    localparam int SCAN_W = ((PA_W > GA_W) ? PA_W : GA_W) + 1;
    localparam int BND_W  = TS_W + 1;
    localparam int PAD_W  = OUT_DATA_W - EID_W - IP_W - CNT_W;

    // configuration
    logic [TICK_W-1:0]  r_ticks;
    logic [MODE_W-1:0]  r_mode;
    logic [CNT_W-1:0]   r_thr;

    // control state
    t_state             r_state, n_state;
    logic               r_started, n_started;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [BND_W-1:0]   r_boundary, n_boundary;
    logic               r_dropped, n_dropped;
    logic [PA_W:0]      r_p_fill, n_p_fill;
    logic [GA_W:0]      r_g_fill, n_g_fill;
    logic [SCAN_W-1:0]  r_idx, n_idx;
    logic               r_flush, n_flush;
    logic [RES_W-1:0]   r_nres, n_nres;
    logic               r_pend_valid, n_pend_valid;
    logic               r_gfound, n_gfound;
    logic               r_out_valid, n_out_valid;

    // payload
    logic [TS_W-1:0]    r_ts, n_ts;
    logic [IP_W-1:0]    r_src, n_src;
    logic [IP_W-1:0]    r_dst, n_dst;
    logic [PORT_W-1:0]  r_port, n_port;
    t_group             r_pend, n_pend;
    logic [GA_W-1:0]    r_gidx, n_gidx;
    logic [CNT_W-1:0]   r_gcnt, n_gcnt;
    logic [EID_W-1:0]   r_out_eid, n_out_eid;
    t_group             r_out_grp, n_out_grp;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;

    // memories
    logic [PAIR_W-1:0]  pair_mem [PAIR_ENTRIES];
    t_group             group_mem [GROUP_ENTRIES];
    logic [PAIR_W-1:0]  p_rdata;
    t_group             g_rdata;
    logic               pair_we, group_we;
    logic [PA_W-1:0]    pair_wa;
    logic [GA_W-1:0]    group_wa;
    t_group             group_wd;

    // helpers
    logic [TICK_W-1:0]  w_eff;
    logic [PAIR_W-1:0]  pk;
    logic [IP_W-1:0]    gk;
    logic [EPOCH_BITS+EID_W-1:0] eid_ext;
    logic               out_free;
    logic               in_p, in_g;
    logic               div_start, div_done;
    logic [TS_W-1:0]    div_quot;
    logic [TICK_W-1:0]  div_rem;
    logic [TS_W-1:0]    in_ts;

    assign w_eff    = (r_ticks == '0) ? TICK_W'(1) : r_ticks;
    assign pk       = (r_mode == MODE_PORT_SCAN) ? {r_src, {(IP_W - PORT_W){1'b0}}, r_port}
                                                 : {r_src, r_dst};
    assign gk       = (r_mode == MODE_DDOS) ? r_dst : r_src;
    assign eid_ext  = {{EID_W{1'b0}}, r_epoch};
    assign out_free = !r_out_valid || i_m_tready;
    assign in_p     = r_idx < SCAN_W'(r_p_fill);
    assign in_g     = r_idx < SCAN_W'(r_g_fill);
    assign in_ts    = i_s_tdata[TS_W-1:0];

    edct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_ts - r_boundary[TS_W-1:0]),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_epoch      = r_epoch;
        n_boundary   = r_boundary;
        n_dropped    = r_dropped;
        n_p_fill     = r_p_fill;
        n_g_fill     = r_g_fill;
        n_idx        = r_idx;
        n_flush      = r_flush;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_gfound     = r_gfound;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_ts         = r_ts;
        n_src        = r_src;
        n_dst        = r_dst;
        n_port       = r_port;
        n_pend       = r_pend;
        n_gidx       = r_gidx;
        n_gcnt       = r_gcnt;
        n_out_eid    = r_out_eid;
        n_out_grp    = r_out_grp;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;
        div_start    = 1'b0;
        pair_we      = 1'b0;
        pair_wa      = r_p_fill[PA_W-1:0];
        group_we     = 1'b0;
        group_wa     = r_g_fill[GA_W-1:0];
        group_wd     = '{key: gk, cnt: CNT_W'(1)};

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_ts     = in_ts;
                    n_src    = i_s_tdata[TS_W+IP_W-1:TS_W];
                    n_dst    = i_s_tdata[TS_W+2*IP_W-1:TS_W+IP_W];
                    n_port   = i_s_tdata[TS_W+2*IP_W+PORT_W-1:TS_W+2*IP_W];
                    n_idx    = '0;
                    n_nres   = '0;
                    n_gfound = 1'b0;
                    n_flush  = (i_s_tuser == KIND_FLUSH);
                    if (i_s_tuser == KIND_FLUSH) begin
                        n_state = S_WALK;
                    end else if (!r_started) begin
                        n_started  = 1'b1;
                        n_boundary = {1'b0, in_ts} + BND_W'(w_eff);
                        n_state    = S_SCAN;
                    end else if ({1'b0, in_ts} >= r_boundary) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (!in_g) begin
                    // end of walk: release the held result as the last one
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_grp   = r_pend;
                            n_out_eid   = eid_ext[EID_W-1:0];
                            n_out_ovf   = r_dropped;
                            n_out_last  = 1'b1;
                        end
                        n_pend_valid = 1'b0;
                        n_p_fill     = '0;
                        n_g_fill     = '0;
                        n_dropped    = 1'b0;
                        n_idx        = '0;
                        n_gfound     = 1'b0;
                        if (r_flush) begin
                            n_epoch    = '0;
                            n_boundary = '0;
                            n_started  = 1'b0;
                            n_state    = S_IDLE;
                        end else begin
                            n_epoch    = r_epoch + div_quot[EPOCH_BITS-1:0] + 1'b1;
                            n_boundary = {1'b0, r_ts} - BND_W'(div_rem) + BND_W'(w_eff);
                            n_state    = S_SCAN;
                        end
                    end
                end else if (g_rdata.cnt >= r_thr && r_nres < RES_W'(MAX_RESULTS)) begin
                    if (!r_pend_valid) begin
                        n_pend       = g_rdata;
                        n_pend_valid = 1'b1;
                        n_nres       = r_nres + 1'b1;
                        n_idx        = r_idx + 1'b1;
                        n_state      = S_WALK;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_grp   = r_pend;
                        n_out_eid   = eid_ext[EID_W-1:0];
                        n_out_ovf   = r_dropped;
                        n_out_last  = 1'b0;
                        n_pend      = g_rdata;
                        n_nres      = r_nres + 1'b1;
                        n_idx       = r_idx + 1'b1;
                        n_state     = S_WALK;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_SCAN: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (in_p && p_rdata == pk) begin
                    // pair already seen this epoch
                    n_state = S_IDLE;
                end else if (in_p || in_g) begin
                    if (in_g && g_rdata.key == gk) begin
                        n_gfound = 1'b1;
                        n_gidx   = r_idx[GA_W-1:0];
                        n_gcnt   = g_rdata.cnt;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                    if (r_p_fill == (PA_W + 1)'(PAIR_ENTRIES) ||
                        (!r_gfound && r_g_fill == (GA_W + 1)'(GROUP_ENTRIES))) begin
                        n_dropped = 1'b1;
                    end else begin
                        pair_we  = 1'b1;
                        n_p_fill = r_p_fill + 1'b1;
                        group_we = 1'b1;
                        if (r_gfound) begin
                            group_wa = r_gidx;
                            group_wd = '{key: gk,
                                         cnt: (r_gcnt == COUNT_MAX) ? r_gcnt : r_gcnt + 1'b1};
                        end else begin
                            n_g_fill = r_g_fill + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= TICK_W'(1000000);
            r_mode       <= '0;
            r_thr        <= CNT_W'(40);
            r_state      <= S_IDLE;
            r_started    <= 1'b0;
            r_epoch      <= '0;
            r_boundary   <= '0;
            r_dropped    <= 1'b0;
            r_p_fill     <= '0;
            r_g_fill     <= '0;
            r_idx        <= '0;
            r_flush      <= 1'b0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_gfound     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_EPOCH_TICKS:     r_ticks <= i_cfg_data;
                    REG_QUERY_MODE:      r_mode  <= i_cfg_data[MODE_W-1:0];
                    REG_COUNT_THRESHOLD: r_thr   <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_state      <= n_state;
            r_started    <= n_started;
            r_epoch      <= n_epoch;
            r_boundary   <= n_boundary;
            r_dropped    <= n_dropped;
            r_p_fill     <= n_p_fill;
            r_g_fill     <= n_g_fill;
            r_idx        <= n_idx;
            r_flush      <= n_flush;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_gfound     <= n_gfound;
            r_out_valid  <= n_out_valid;
        end
        r_ts       <= n_ts;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_port     <= n_port;
        r_pend     <= n_pend;
        r_gidx     <= n_gidx;
        r_gcnt     <= n_gcnt;
        r_out_eid  <= n_out_eid;
        r_out_grp  <= n_out_grp;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    // pair memory: one write, one registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            pair_mem[pair_wa] <= pk;
        end
        p_rdata <= pair_mem[r_idx[PA_W-1:0]];
    end

    // group memory: key and distinct count per group
    always_ff @(posedge i_clk) begin
        if (group_we) begin
            group_mem[group_wa] <= group_wd;
        end
        g_rdata <= group_mem[r_idx[GA_W-1:0]];
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{PAD_W{1'b0}}, r_out_grp.cnt, r_out_grp.key, r_out_eid};
    assign o_m_tuser   = r_out_ovf;
    assign o_m_tlast   = r_out_last;

    // fill counts never pass the memory depths
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_fill <= (PA_W + 1)'(PAIR_ENTRIES) && r_g_fill <= (GA_W + 1)'(GROUP_ENTRIES))
        else $error("fill count beyond memory depth");

    // no more results per close than the cap
    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(MAX_RESULTS))
        else $error("result cap exceeded");

    // before the first packet of a run the epoch state is cleared
    a_not_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_epoch == '0 && r_boundary == '0))
        else $error("epoch state set while no epoch is open");

    // a held result is only released with an open output slot
    a_pend_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCHK && r_pend_valid && r_out_valid && !i_m_tready) |=>
        $stable(r_pend))
        else $error("held result overwritten while output stalled");
endmodule

### rtl/core/edct_div.sv
// restoring divider, one quotient bit per cycle, for the epoch skip count
`timescale 1ns / 1ps
module edct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [edct_pkg::TS_W-1:0]     i_dividend,
    input  logic [edct_pkg::TICK_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [edct_pkg::TS_W-1:0]     o_quot,
    output logic [edct_pkg::TICK_W-1:0]   o_rem
);
    import edct_pkg::*;

    localparam int STEP_W = $clog2(TS_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [TS_W-1:0]     r_q, n_q;
    logic [TICK_W-1:0]   r_rem, n_rem;
    logic [TICK_W-1:0]   r_div, n_div;
    logic [TICK_W:0]     trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_q[TS_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, r_div}) begin
                n_rem = TICK_W'(trial - {1'b0, r_div});
                n_q   = {r_q[TS_W-2:0], 1'b1};
            end else begin
                n_rem = trial[TICK_W-1:0];
                n_q   = {r_q[TS_W-2:0], 1'b0};
            end
            if (r_cnt == STEP_W'(TS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
